// File: design/ddl_pkg.sv
// Shared types and constants for the dashed line rasterizer.
// No dependencies; imported by the controller, datapath and top level.
package ddl_pkg;

   localparam int DASH_BITS = 4;
   localparam logic [DASH_BITS-1:0] DASH_LENGTH_RESET = 4'd10;
   localparam logic [DASH_BITS-1:0] DASH_COUNT_RESET = 4'd1;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef struct packed {
      logic start;
      logic step;
      logic div_iter;
      logic div_last;
   } ddl_cmd_type;

   typedef struct packed {
      logic line_active;
      logic zero_len;
   } ddl_status_type;

endpackage

// File: design/ddl_datapath.sv
// Datapath of the dashed line rasterizer: endpoints, serial divider, position,
// dash counter and result register. Depends on ddl_pkg; driven by ddl_controller.
module ddl_datapath #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ddl_pkg::ddl_cmd_type              cmd,
   output ddl_pkg::ddl_status_type           status,
   input  logic [COORD_BITS-1:0]             req_start_x,
   input  logic [COORD_BITS-1:0]             req_start_y,
   input  logic [COORD_BITS-1:0]             req_end_x,
   input  logic [COORD_BITS-1:0]             req_end_y,
   input  logic                              req_dashed,
   input  logic                              csr_write_enable,
   input  logic [ddl_pkg::DASH_BITS-1:0]     csr_write_data,
   output logic [COORD_BITS-1:0]             rsp_pixel_x,
   output logic [COORD_BITS-1:0]             rsp_pixel_y,
   output logic                              rsp_visible,
   output logic                              rsp_last
);
   import ddl_pkg::*;

   localparam int C = COORD_BITS;
   localparam int F = FRAC_BITS;
   localparam int POS_W = C + F;
   localparam int INC_W = C + F + 1;

   logic [C:0]           dx_w, dy_w;
   logic                 dx_neg, dy_neg;
   logic [C-1:0]         adx, ady, steps;

   logic [POS_W-1:0]     pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic [INC_W-1:0]     inc_x_ff, inc_y_ff, inc_x_in, inc_y_in;
   logic [C-1:0]         steps_left_ff, steps_left_in;
   logic [DASH_BITS-1:0] dash_count_ff, dash_count_in, dash_inc;
   logic                 draw_on_ff, draw_on_in;
   logic                 dash_mode_ff, dash_mode_in;
   logic                 line_active_ff, line_active_in;
   logic [DASH_BITS-1:0] dash_length_ff;

   logic [C:0]           rem_x_ff, rem_y_ff, rem_x_in, rem_y_in, diff_x, diff_y;
   logic [C-1:0]         div_ff;
   logic [F:0]           quo_x_ff, quo_y_ff, quo_x_next, quo_y_next;
   logic                 neg_x_ff, neg_y_ff;
   logic                 ge_x, ge_y;
   logic [INC_W-1:0]     ext_x, ext_y;

   logic [POS_W-1:0]     sum_x, sum_y;

   logic [C-1:0]         pix_x_ff, pix_y_ff;
   logic                 vis_ff, last_ff;

   assign dx_w   = {1'b0, req_end_x} - {1'b0, req_start_x};
   assign dy_w   = {1'b0, req_end_y} - {1'b0, req_start_y};
   assign dx_neg = dx_w[C];
   assign dy_neg = dy_w[C];
   assign adx    = dx_neg ? (~dx_w[C-1:0] + 1'b1) : dx_w[C-1:0];
   assign ady    = dy_neg ? (~dy_w[C-1:0] + 1'b1) : dy_w[C-1:0];
   assign steps  = (adx > ady) ? adx : ady;

   assign status.zero_len    = (steps == '0);
   assign status.line_active = line_active_ff;

   assign ge_x       = rem_x_ff >= {1'b0, div_ff};
   assign ge_y       = rem_y_ff >= {1'b0, div_ff};
   assign diff_x     = ge_x ? rem_x_ff - {1'b0, div_ff} : rem_x_ff;
   assign diff_y     = ge_y ? rem_y_ff - {1'b0, div_ff} : rem_y_ff;
   assign quo_x_next = {quo_x_ff[F-1:0], ge_x};
   assign quo_y_next = {quo_y_ff[F-1:0], ge_y};
   assign ext_x      = {{C{1'b0}}, quo_x_next};
   assign ext_y      = {{C{1'b0}}, quo_y_next};

   // position is held with the rounding half already added
   assign sum_x    = pos_x_ff + inc_x_ff[POS_W-1:0];
   assign sum_y    = pos_y_ff + inc_y_ff[POS_W-1:0];
   assign dash_inc = dash_count_ff + 1'b1;

   always_comb begin
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      inc_x_in       = inc_x_ff;
      inc_y_in       = inc_y_ff;
      steps_left_in  = steps_left_ff;
      dash_count_in  = dash_count_ff;
      draw_on_in     = draw_on_ff;
      dash_mode_in   = dash_mode_ff;
      line_active_in = line_active_ff;
      rem_x_in       = rem_x_ff;
      rem_y_in       = rem_y_ff;
      if (cmd.start) begin
         pos_x_in       = {req_start_x, 1'b1, {(F-1){1'b0}}};
         pos_y_in       = {req_start_y, 1'b1, {(F-1){1'b0}}};
         steps_left_in  = steps;
         dash_count_in  = DASH_COUNT_RESET;
         draw_on_in     = 1'b1;
         dash_mode_in   = req_dashed;
         line_active_in = (steps != '0);
         rem_x_in       = {1'b0, adx};
         rem_y_in       = {1'b0, ady};
      end else if (cmd.step) begin
         pos_x_in      = sum_x;
         pos_y_in      = sum_y;
         steps_left_in = steps_left_ff - 1'b1;
         if (dash_inc == dash_length_ff) begin
            dash_count_in = '0;
            draw_on_in    = ~draw_on_ff;
         end else begin
            dash_count_in = dash_inc;
         end
         if (steps_left_ff == {{(C-1){1'b0}}, 1'b1}) begin
            line_active_in = 1'b0;
         end
      end else if (cmd.div_iter) begin
         rem_x_in = {diff_x[C-1:0], 1'b0};
         rem_y_in = {diff_y[C-1:0], 1'b0};
         if (cmd.div_last) begin
            inc_x_in = neg_x_ff ? (~ext_x + 1'b1) : ext_x;
            inc_y_in = neg_y_ff ? (~ext_y + 1'b1) : ext_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dash_count_ff  <= DASH_COUNT_RESET;
         draw_on_ff     <= 1'b1;
         dash_mode_ff   <= 1'b0;
         line_active_ff <= 1'b0;
         dash_length_ff <= DASH_LENGTH_RESET;
      end else begin
         dash_count_ff  <= dash_count_in;
         draw_on_ff     <= draw_on_in;
         dash_mode_ff   <= dash_mode_in;
         line_active_ff <= line_active_in;
         if (csr_write_enable) begin
            dash_length_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff      <= pos_x_in;
      pos_y_ff      <= pos_y_in;
      inc_x_ff      <= inc_x_in;
      inc_y_ff      <= inc_y_in;
      steps_left_ff <= steps_left_in;
      rem_x_ff      <= rem_x_in;
      rem_y_ff      <= rem_y_in;
      if (cmd.start) begin
         div_ff   <= steps;
         neg_x_ff <= dx_neg;
         neg_y_ff <= dy_neg;
         quo_x_ff <= '0;
         quo_y_ff <= '0;
      end else if (cmd.div_iter) begin
         quo_x_ff <= quo_x_next;
         quo_y_ff <= quo_y_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pix_x_ff <= req_start_x;
         pix_y_ff <= req_start_y;
         vis_ff   <= 1'b1;
         last_ff  <= (steps == '0);
      end else if (cmd.step) begin
         pix_x_ff <= sum_x[POS_W-1:F];
         pix_y_ff <= sum_y[POS_W-1:F];
         vis_ff   <= ~dash_mode_ff | draw_on_ff;
         last_ff  <= (steps_left_ff == {{(C-1){1'b0}}, 1'b1});
      end
   end

   assign rsp_pixel_x = pix_x_ff;
   assign rsp_pixel_y = pix_y_ff;
   assign rsp_visible = vis_ff;
   assign rsp_last    = last_ff;

endmodule

// File: design/ddl_controller.sv
// Controller of the dashed line rasterizer: handshakes and division sequencing.
// Depends on ddl_pkg; commands ddl_datapath through ddl_cmd_type.
module ddl_controller #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_command,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ddl_pkg::ddl_cmd_type    cmd,
   input  ddl_pkg::ddl_status_type status
);
   import ddl_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DIV  = 1'b1;

   logic             state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept, emit;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.start    = accept && (req_command == CMD_START);
      cmd.step     = accept && (req_command == CMD_STEP) && status.line_active;
      cmd.div_iter = (state_ff == ST_DIV);
      cmd.div_last = (state_ff == ST_DIV) && (cnt_ff == CNT_LAST);
   end

   assign emit = cmd.start || cmd.step;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start && !status.zero_len) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end
         end
         ST_DIV: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_accept_in_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !req_ready)
      else $error("request taken during division");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !emit)
      else $error("pending result overwritten");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && (cnt_ff != CNT_LAST)) |=> (state_ff == ST_DIV))
      else $error("division ended early");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.div_last |=> (state_ff == ST_IDLE))
      else $error("division did not end");

endmodule

// File: design/dda_dashed_line_rasterizer_unit.sv
// Top level of the DDA dashed line rasterizer.
// Depends on ddl_pkg, ddl_controller and ddl_datapath.
//
//   channel   direction   handshake                 payload
//   req       in          req_valid / req_ready     command, endpoints, dashed
//   rsp       out         rsp_valid / rsp_ready     pixel x/y, visible, last
//   csr       in          csr_write_enable          dash_length
//
// Step commands give a pixel per cycle while rsp_ready stays high.
// A start command emits its first pixel at once, then the serial divider runs
// with req_ready low until the increments are set; a zero-length line skips the divider.
// Reset is synchronous; no clearing pass. A stalled result blocks new requests.
module dda_dashed_line_rasterizer_unit #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [COORD_BITS-1:0]         req_start_x,
   input  logic [COORD_BITS-1:0]         req_start_y,
   input  logic [COORD_BITS-1:0]         req_end_x,
   input  logic [COORD_BITS-1:0]         req_end_y,
   input  logic                          req_dashed,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [COORD_BITS-1:0]         rsp_pixel_x,
   output logic [COORD_BITS-1:0]         rsp_pixel_y,
   output logic                          rsp_visible,
   output logic                          rsp_last,
   input  logic                          csr_write_enable,
   input  logic [ddl_pkg::DASH_BITS-1:0] csr_write_data
);
   import ddl_pkg::*;

   ddl_cmd_type    cmd;
   ddl_status_type status;

   ddl_controller #(
      .FRAC_BITS(FRAC_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .status      (status)
   );

   ddl_datapath #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_dashed       (req_dashed),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_visible      (rsp_visible),
      .rsp_last         (rsp_last)
   );

endmodule
